// ----- hdl/dfac_pkg.sv -----
// Shared types and constants for the double to aligned fixed-point converter.
package dfac_pkg;

    // Command codes carried in tuser.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam int          DATA_W      = 64;
    localparam int          EXP_W       = 11;
    localparam int          FRAC_W      = 52;
    localparam int          AMT_W       = 6;
    localparam int          EXB_W       = 14;
    localparam logic [10:0] EXP_MAX     = 11'h7ff;
    localparam logic [63:0] SIGN_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam logic [5:0]  HIDDEN_POS  = 6'd52;
    localparam logic [5:0]  ROUND_POS   = 6'd53;
    localparam logic [5:0]  MAX_RSHIFT  = 6'd62;
    localparam int          EXP_ADJUST  = 4;

    // One item as it moves down the pipeline.
    typedef struct packed {
        logic                     cmd;
        logic                     special;
        logic                     nan;
        logic                     sign;
        logic                     zero_shift;
        logic                     right;
        logic [AMT_W-1:0]         amt;
        logic [EXP_W-1:0]         maxe;
        logic signed [EXB_W-1:0]  ex_base;
        logic [DATA_W-1:0]        data;
    } t_item;

endpackage

// ----- hdl/dfac_front.sv -----
// First stage: significand build, shared negation, special cases and encode shift amount.
module dfac_front #(
    parameter int SPARE_BITS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [63:0]          i_value,
    input  logic [10:0]          i_maxe,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dfac_pkg::t_item      o_item
);

    logic                r_valid;
    dfac_pkg::t_item     r_item;
    dfac_pkg::t_item     n_item;
    logic [10:0]         own_exp;
    logic [63:0]         sig;
    logic [63:0]         neg_src;
    logic signed [12:0]  shift_s;
    logic                load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    assign own_exp = i_value[62:52];
    assign sig     = {11'b0, (own_exp != 11'd0), i_value[dfac_pkg::FRAC_W-1:0]};
    assign neg_src = (i_cmd == dfac_pkg::CMD_DECODE) ? i_value : sig;
    assign shift_s = $signed(13'(SPARE_BITS)) + $signed({2'b00, i_maxe})
                     - $signed({2'b00, own_exp});

    // Both commands negate when the sign bit is set, so one negator serves.
    always_comb begin
        n_item            = '0;
        n_item.cmd        = i_cmd;
        n_item.sign       = i_value[63];
        n_item.maxe       = i_maxe;
        n_item.data       = i_value[63] ? (~neg_src + 64'd1) : neg_src;
        n_item.right      = 1'b1;
        if (i_cmd == dfac_pkg::CMD_DECODE) begin
            n_item.nan     = (i_maxe == dfac_pkg::EXP_MAX) || (i_value == dfac_pkg::SIGN_MIN);
            n_item.special = n_item.nan || (i_value == 64'd0);
        end else begin
            // Clamp the alignment shift; the stored amount is one less so the
            // last dropped bit survives for rounding.
            if (shift_s <= 13'sd0) begin
                n_item.zero_shift = 1'b1;
                n_item.amt        = '0;
            end else if (shift_s > 13'sd63) begin
                n_item.amt = dfac_pkg::MAX_RSHIFT;
            end else begin
                n_item.amt = 6'(shift_s - 13'sd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hdl/dfac_lzc.sv -----
// Second stage: leading-one search for decode, giving shift direction, amount and exponent base.
module dfac_lzc #(
    parameter int SPARE_BITS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dfac_pkg::t_item      i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dfac_pkg::t_item      o_item
);

    logic             r_valid;
    dfac_pkg::t_item  r_item;
    dfac_pkg::t_item  n_item;
    logic [5:0]       msb_pos;
    logic             load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Position of the highest set bit of the magnitude (below the sign bit).
    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < 63; i++) begin
            if (i_item.data[i]) begin
                msb_pos = 6'(i);
            end
        end
    end

    // Decode normalizes the leading one to the hidden-bit position.
    always_comb begin
        n_item = i_item;
        if (i_item.cmd == dfac_pkg::CMD_DECODE) begin
            n_item.right   = (msb_pos >= dfac_pkg::ROUND_POS);
            n_item.amt     = n_item.right ? (msb_pos - dfac_pkg::ROUND_POS)
                                          : (dfac_pkg::HIDDEN_POS - msb_pos);
            n_item.ex_base = $signed({3'b000, i_item.maxe}) + $signed({8'b0, msb_pos})
                             - $signed(14'({8'b0, dfac_pkg::HIDDEN_POS}))
                             - $signed(14'(SPARE_BITS))
                             + $signed(14'(dfac_pkg::EXP_ADJUST));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hdl/dfac_shift.sv -----
// Third stage: the shared barrel shifter for alignment and normalization.
module dfac_shift (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dfac_pkg::t_item      i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dfac_pkg::t_item      o_item
);

    logic             r_valid;
    dfac_pkg::t_item  r_item;
    dfac_pkg::t_item  n_item;
    logic             load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Encode shifts arithmetically; decode shifts the positive magnitude either way.
    always_comb begin
        n_item = i_item;
        if (i_item.cmd == dfac_pkg::CMD_ENCODE) begin
            n_item.data = 64'($signed(i_item.data) >>> i_item.amt);
        end else if (i_item.right) begin
            n_item.data = i_item.data >> i_item.amt;
        end else begin
            n_item.data = i_item.data << i_item.amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- hdl/dfac_pack.sv -----
// Fourth stage: rounding, exponent range checks and result packing.
module dfac_pack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dfac_pkg::t_item      i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_result,
    output logic                 o_nan
);

    logic                     r_valid;
    logic [63:0]              r_result;
    logic                     r_nan;
    logic [63:0]              n_result;
    logic                     n_nan;
    logic [53:0]              rounded;
    logic                     carry;
    logic [51:0]              frac;
    logic signed [13:0]       ex;
    logic                     load;

    assign load     = !r_valid || i_ready;
    assign o_ready  = load;
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_nan    = r_nan;

    // Decode rounding: the kept low bit is the last dropped bit.
    assign rounded = {1'b0, i_item.data[53:1]} + {53'b0, i_item.data[0]};
    assign carry   = i_item.right && rounded[53];
    assign frac    = !i_item.right ? i_item.data[51:0] :
                     (carry ? 52'd0 : rounded[51:0]);
    assign ex      = i_item.ex_base + $signed({13'b0, carry});

    always_comb begin
        n_nan    = 1'b0;
        n_result = '0;
        if (i_item.cmd == dfac_pkg::CMD_ENCODE) begin
            if (i_item.zero_shift) begin
                n_result = i_item.data;
            end else begin
                n_result = 64'($signed(i_item.data) >>> 1) + {63'b0, i_item.data[0]};
            end
        end else if (i_item.special) begin
            n_nan    = i_item.nan;
            n_result = i_item.nan ? dfac_pkg::ALL_ONES : 64'd0;
        end else if (ex <= 14'sd0) begin
            n_result = '0;
        end else if (ex >= $signed({3'b000, dfac_pkg::EXP_MAX})) begin
            n_nan    = 1'b1;
            n_result = dfac_pkg::ALL_ONES;
        end else begin
            n_result = {i_item.sign, ex[10:0], frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_result <= n_result;
            r_nan    <= n_nan;
        end
    end

endmodule

// ----- hdl/double_fixed_align_convert.sv -----
// Top level of the converter between IEEE doubles and aligned fixed-point integers.
//
//  Channel  Direction  Carries
//  s_*      in         tuser: command; tdata: value_bits [63:0], max_exponent [74:64]
//  m_*      out        tuser: made_nan; tdata: result_bits [63:0]
//
// Four register stages (negate, leading-one search, barrel shift, round and pack)
// take one request in every cycle while the output is not stalled.
// Each stage holds its own valid bit; a stage refills as soon as its request moves on,
// so a stall at the output backs up stage by stage and nothing is lost or repeated.
// Reset (synchronous, active low) clears only the valid bits.
module double_fixed_align_convert #(
    parameter int SPARE_BITS = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // value_bits [63:0], max_exponent [74:64], zero pad
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_bits [63:0]
    output logic         m_tuser    // made_nan
);

    logic             v1, v2, v3;
    logic             rdy2, rdy3, rdy4;
    dfac_pkg::t_item  item1, item2, item3;

    dfac_front #(.SPARE_BITS(SPARE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_cmd   (s_tuser),
        .i_value (s_tdata[63:0]),
        .i_maxe  (s_tdata[74:64]),
        .o_valid (v1),
        .i_ready (rdy2),
        .o_item  (item1)
    );

    dfac_lzc #(.SPARE_BITS(SPARE_BITS)) u_lzc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_ready (rdy2),
        .i_item  (item1),
        .o_valid (v2),
        .i_ready (rdy3),
        .o_item  (item2)
    );

    dfac_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_ready (rdy3),
        .i_item  (item2),
        .o_valid (v3),
        .i_ready (rdy4),
        .o_item  (item3)
    );

    dfac_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v3),
        .o_ready  (rdy4),
        .i_item   (item3),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (m_tdata),
        .o_nan    (m_tuser)
    );

endmodule
